>>> hw/rtl/lrk4_pkg.sv
// Package for the Lorenz RK4 stepper: fixed-point constants, saturation and
// divide-by-six helpers, micro-operation types and the micro-program table.
// Used by lrk4_ctrl, lrk4_datapath and lorenz_rk4_stepper. No dependencies.
`default_nettype none

package lrk4_pkg;

  localparam int FRAC_BITS = 24;
  localparam int COORD_W   = 32;
  localparam int SCALE_W   = 17;
  localparam int TICK_W    = 16;
  localparam int ACC_W     = 36;

  localparam logic signed [COORD_W-1:0] SIGMA_Q = 32'sd167772160;
  localparam logic signed [COORD_W-1:0] BETA_Q  = 32'sd44739243;
  localparam logic signed [COORD_W-1:0] HALF_Q  = 32'sd8388608;
  localparam logic signed [COORD_W-1:0] X_RESET = 32'sd1677722;
  localparam logic [SCALE_W-1:0]        SCALE_RESET = 17'd65536;

  // Offset of six times 2^32 keeps the dividend of the final division positive.
  localparam logic signed [ACC_W-1:0] DIV_OFFSET = 36'sd25769803776;
  localparam logic signed [63:0]      QUOT_OFFSET = 64'sd4294967296;
  localparam int DIV_STEPS = 9;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam int PC_W = 6;
  localparam logic [PC_W-1:0] PC_LAST = 6'd61;

  typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL} op_t;

  typedef enum logic [4:0] {
    SRC_ZERO, SRC_X, SRC_Y, SRC_Z, SRC_PX, SRC_PY, SRC_PZ,
    SRC_T0, SRC_T1, SRC_T2, SRC_KX, SRC_KY, SRC_KZ,
    SRC_RHO, SRC_DT, SRC_SIGMA, SRC_BETA, SRC_HALF
  } src_t;

  typedef enum logic [3:0] {
    DST_PX, DST_PY, DST_PZ, DST_T0, DST_T1, DST_T2, DST_KX, DST_KY, DST_KZ
  } dst_t;

  typedef enum logic [1:0] {ACC_NONE, ACC_LOAD, ACC_ONE, ACC_TWO} acc_t;

  typedef struct packed {
    op_t  op;
    src_t src_a;
    src_t src_b;
    dst_t dst;
    acc_t acc;
  } uop_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic mul_wb;
    logic div_init;
    logic div_step;
    logic commit;
    logic push;
    uop_t uop;
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } sts_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RUN, ST_MULW, ST_DINIT, ST_DIV, ST_COMMIT, ST_PUSH
  } state_t;

  typedef struct packed {
    logic [2:0] rem;
    logic [3:0] quo;
  } digit_t;

  function automatic logic signed [COORD_W-1:0] sat64(input logic signed [63:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

  // Four bits of long division by six; the remainder stays below six.
  function automatic digit_t div6_digit(input logic [2:0] rem, input logic [3:0] bits);
    digit_t     d;
    logic [3:0] t;
    d.rem = rem;
    d.quo = '0;
    for (int j = 3; j >= 0; j--) begin
      t = {d.rem, bits[j]};
      if (t >= 4'd6) begin
        d.rem  = 3'(t - 4'd6);
        d.quo[j] = 1'b1;
      end else begin
        d.rem  = t[2:0];
      end
    end
    return d;
  endfunction

  function automatic uop_t mk(input op_t op, input src_t a, input src_t b,
                              input dst_t d, input acc_t acc);
    uop_t u;
    u.op    = op;
    u.src_a = a;
    u.src_b = b;
    u.dst   = d;
    u.acc   = acc;
    return u;
  endfunction

  // One derivative evaluation at the trial point, ending with k = f * dt.
  function automatic uop_t deriv_uop(input logic [PC_W-1:0] i, input acc_t acc);
    uop_t u;
    case (i)
      6'd0:    u = mk(OP_SUB, SRC_PY,    SRC_PX, DST_T0, ACC_NONE);
      6'd1:    u = mk(OP_MUL, SRC_SIGMA, SRC_T0, DST_T0, ACC_NONE);
      6'd2:    u = mk(OP_SUB, SRC_RHO,   SRC_PZ, DST_T1, ACC_NONE);
      6'd3:    u = mk(OP_MUL, SRC_PX,    SRC_T1, DST_T1, ACC_NONE);
      6'd4:    u = mk(OP_SUB, SRC_T1,    SRC_PY, DST_T1, ACC_NONE);
      6'd5:    u = mk(OP_MUL, SRC_PX,    SRC_PY, DST_T2, ACC_NONE);
      6'd6:    u = mk(OP_MUL, SRC_BETA,  SRC_PZ, DST_KX, ACC_NONE);
      6'd7:    u = mk(OP_SUB, SRC_T2,    SRC_KX, DST_T2, ACC_NONE);
      6'd8:    u = mk(OP_MUL, SRC_T0,    SRC_DT, DST_KX, acc);
      6'd9:    u = mk(OP_MUL, SRC_T1,    SRC_DT, DST_KY, acc);
      default: u = mk(OP_MUL, SRC_T2,    SRC_DT, DST_KZ, acc);
    endcase
    return u;
  endfunction

  // Trial point at the midpoint: p = s + k * 0.5.
  function automatic uop_t half_uop(input logic [PC_W-1:0] i);
    uop_t u;
    case (i)
      6'd0:    u = mk(OP_MUL, SRC_KX, SRC_HALF, DST_PX, ACC_NONE);
      6'd1:    u = mk(OP_ADD, SRC_X,  SRC_PX,   DST_PX, ACC_NONE);
      6'd2:    u = mk(OP_MUL, SRC_KY, SRC_HALF, DST_PY, ACC_NONE);
      6'd3:    u = mk(OP_ADD, SRC_Y,  SRC_PY,   DST_PY, ACC_NONE);
      6'd4:    u = mk(OP_MUL, SRC_KZ, SRC_HALF, DST_PZ, ACC_NONE);
      default: u = mk(OP_ADD, SRC_Z,  SRC_PZ,   DST_PZ, ACC_NONE);
    endcase
    return u;
  endfunction

  function automatic uop_t uop_rom(input logic [PC_W-1:0] pc);
    uop_t u;
    if (pc == 6'd0) begin
      u = mk(OP_ADD, SRC_X, SRC_ZERO, DST_PX, ACC_NONE);
    end else if (pc == 6'd1) begin
      u = mk(OP_ADD, SRC_Y, SRC_ZERO, DST_PY, ACC_NONE);
    end else if (pc == 6'd2) begin
      u = mk(OP_ADD, SRC_Z, SRC_ZERO, DST_PZ, ACC_NONE);
    end else if (pc < 6'd14) begin
      u = deriv_uop(pc - 6'd3, ACC_LOAD);
    end else if (pc < 6'd20) begin
      u = half_uop(pc - 6'd14);
    end else if (pc < 6'd31) begin
      u = deriv_uop(pc - 6'd20, ACC_TWO);
    end else if (pc < 6'd37) begin
      u = half_uop(pc - 6'd31);
    end else if (pc < 6'd48) begin
      u = deriv_uop(pc - 6'd37, ACC_TWO);
    end else if (pc == 6'd48) begin
      u = mk(OP_ADD, SRC_X, SRC_KX, DST_PX, ACC_NONE);
    end else if (pc == 6'd49) begin
      u = mk(OP_ADD, SRC_Y, SRC_KY, DST_PY, ACC_NONE);
    end else if (pc == 6'd50) begin
      u = mk(OP_ADD, SRC_Z, SRC_KZ, DST_PZ, ACC_NONE);
    end else begin
      u = deriv_uop(pc - 6'd51, ACC_ONE);
    end
    return u;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/lorenz_rk4_stepper.sv
// Lorenz attractor stepper: each accepted item (a tick time) advances the
// kept point (x, y, z) by one fourth-order Runge-Kutta step of ten times the
// tick, with sigma 10, beta 8/3 and rho 28 times rho_scale, all in saturating
// signed Q7.24, and returns the new point as one result item. The point
// resets to (0.1, 0, 0) and rho_scale to 1.0. An item is not accepted until
// the previous one is in the output register: the sequencer runs a 62-step
// micro-program on a single shared adder and a single 32x32 multiplier (each
// multiply is issued, then written back, 34 of them per step), then divides
// the three weighted increments by six four bits a cycle. The result sits in
// an output register, so a new item is taken while it waits.
// rho_scale may be written only while the block is idle.
// Depends on lrk4_pkg, lrk4_ctrl and lrk4_datapath.
`default_nettype none

module lorenz_rk4_stepper (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wr_en,
  input  wire logic [lrk4_pkg::SCALE_W-1:0]    cfg_wr_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [lrk4_pkg::TICK_W-1:0]     time_step,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic signed [lrk4_pkg::COORD_W-1:0]  pos_x,
  output logic signed [lrk4_pkg::COORD_W-1:0]  pos_y,
  output logic signed [lrk4_pkg::COORD_W-1:0]  pos_z
);
  import lrk4_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lrk4_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  lrk4_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .time_step   (time_step),
    .cmd         (cmd),
    .sts         (sts),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z)
  );

endmodule

`default_nettype wire

>>> hw/rtl/lrk4_ctrl.sv
// Sequencer for the Lorenz RK4 stepper: walks the micro-program, runs the
// final division and hands results to the output register.
// Depends on lrk4_pkg.
`default_nettype none

module lrk4_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  input  lrk4_pkg::sts_t     sts,
  output lrk4_pkg::cmd_t     cmd
);
  import lrk4_pkg::*;

  state_t          state, state_next;
  logic [PC_W-1:0] pc, pc_next;
  logic            out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pc        <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pc        <= pc_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    pc_next    = pc;
    in_stall   = 1'b1;
    cmd        = '0;
    cmd.uop    = uop_rom(pc);
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          pc_next    = '0;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
        if (cmd.uop.op == OP_MUL) begin
          state_next = ST_MULW;
        end else if (pc == PC_LAST) begin
          state_next = ST_DINIT;
        end else begin
          pc_next = pc + 1'b1;
        end
      end
      ST_MULW: begin
        cmd.mul_wb = 1'b1;
        if (pc == PC_LAST) begin
          state_next = ST_DINIT;
        end else begin
          pc_next    = pc + 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_DINIT: begin
        cmd.div_init = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = ST_PUSH;
      end
      ST_PUSH: begin
        if (!out_valid || !out_stall) begin
          cmd.push   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.push) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  // A result must never overwrite one that is still held by a stalled consumer.
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> (!out_valid || !out_stall))
    else $error("result pushed over a stalled item");

  // Every multiply issue is followed by its write-back cycle.
  a_mul_wb: assert property (@(posedge clk) disable iff (rst)
    (cmd.issue && cmd.uop.op == OP_MUL) |=> (state == ST_MULW))
    else $error("multiply issued without write-back");

  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN || state == ST_MULW) |-> (pc <= PC_LAST))
    else $error("micro-program counter out of range");

  // The program always finishes with the division before a result is pushed.
  a_div_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COMMIT) |-> ($past(state) == ST_DIV && $past(sts.div_last)))
    else $error("commit without completed division");

endmodule

`default_nettype wire

>>> hw/rtl/lrk4_datapath.sv
// Datapath of the Lorenz RK4 stepper: point and temporary registers, one
// saturating adder, one 32x32 multiplier, increment accumulators and
// three divide-by-six lanes. Depends on lrk4_pkg.
`default_nettype none

module lrk4_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wr_en,
  input  wire logic [lrk4_pkg::SCALE_W-1:0]    cfg_wr_data,
  input  wire logic [lrk4_pkg::TICK_W-1:0]     time_step,
  input  lrk4_pkg::cmd_t                       cmd,
  output lrk4_pkg::sts_t                       sts,
  output logic signed [lrk4_pkg::COORD_W-1:0]  pos_x,
  output logic signed [lrk4_pkg::COORD_W-1:0]  pos_y,
  output logic signed [lrk4_pkg::COORD_W-1:0]  pos_z
);
  import lrk4_pkg::*;

  logic [SCALE_W-1:0]          rho_scale;
  logic signed [COORD_W-1:0]   coord [3];
  logic signed [COORD_W-1:0]   pt    [3];
  logic signed [COORD_W-1:0]   tmp   [3];
  logic signed [COORD_W-1:0]   kv    [3];
  logic signed [COORD_W-1:0]   rho_q, dt_q;
  logic signed [63:0]          prod;
  logic signed [ACC_W-1:0]     acc   [3];
  logic [ACC_W-1:0]            dvd   [3];
  logic [2:0]                  rem   [3];
  logic [DIV_CNT_W-1:0]        div_cnt;

  logic signed [COORD_W-1:0]   opa, opb, wb_val;
  logic signed [63:0]          prod_c, rnd;
  logic signed [ACC_W-1:0]     k_ext;
  logic                        wb_en;
  logic [1:0]                  k_lane;
  logic                        k_wr;

  function automatic logic signed [COORD_W-1:0] pick(
    input src_t s,
    input logic signed [COORD_W-1:0] c0, c1, c2, p0, p1, p2,
    input logic signed [COORD_W-1:0] t0, t1, t2, k0, k1, k2, rq, dq);
    logic signed [COORD_W-1:0] v;
    case (s)
      SRC_ZERO:  v = '0;
      SRC_X:     v = c0;
      SRC_Y:     v = c1;
      SRC_Z:     v = c2;
      SRC_PX:    v = p0;
      SRC_PY:    v = p1;
      SRC_PZ:    v = p2;
      SRC_T0:    v = t0;
      SRC_T1:    v = t1;
      SRC_T2:    v = t2;
      SRC_KX:    v = k0;
      SRC_KY:    v = k1;
      SRC_KZ:    v = k2;
      SRC_RHO:   v = rq;
      SRC_DT:    v = dq;
      SRC_SIGMA: v = SIGMA_Q;
      SRC_BETA:  v = BETA_Q;
      SRC_HALF:  v = HALF_Q;
      default:   v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    opa = pick(cmd.uop.src_a, coord[0], coord[1], coord[2], pt[0], pt[1], pt[2],
               tmp[0], tmp[1], tmp[2], kv[0], kv[1], kv[2], rho_q, dt_q);
    opb = pick(cmd.uop.src_b, coord[0], coord[1], coord[2], pt[0], pt[1], pt[2],
               tmp[0], tmp[1], tmp[2], kv[0], kv[1], kv[2], rho_q, dt_q);
  end

  assign prod_c = opa * opb;
  // Round half up: add half an LSB, then floor by the arithmetic shift.
  assign rnd    = (prod + 64'sd8388608) >>> FRAC_BITS;

  always_comb begin
    wb_en  = 1'b0;
    wb_val = sat64(rnd);
    if (cmd.mul_wb) begin
      wb_en = 1'b1;
    end else if (cmd.issue && cmd.uop.op == OP_ADD) begin
      wb_en  = 1'b1;
      wb_val = sat64(64'(opa) + 64'(opb));
    end else if (cmd.issue && cmd.uop.op == OP_SUB) begin
      wb_en  = 1'b1;
      wb_val = sat64(64'(opa) - 64'(opb));
    end
  end

  always_comb begin
    k_wr   = 1'b0;
    k_lane = 2'd0;
    case (cmd.uop.dst)
      DST_KX:  begin k_wr = 1'b1; k_lane = 2'd0; end
      DST_KY:  begin k_wr = 1'b1; k_lane = 2'd1; end
      DST_KZ:  begin k_wr = 1'b1; k_lane = 2'd2; end
      default: begin k_wr = 1'b0; k_lane = 2'd0; end
    endcase
  end

  assign k_ext = ACC_W'(wb_val);

  always_ff @(posedge clk) begin
    if (rst) begin
      rho_scale <= SCALE_RESET;
    end else if (cfg_wr_en) begin
      rho_scale <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dt_q  <= COORD_W'({TICK_W'(time_step) * 20'd10, 8'd0});
      rho_q <= COORD_W'({rho_scale * 22'd28, 8'd0});
    end
    if (cmd.issue && cmd.uop.op == OP_MUL) begin
      prod <= prod_c;
    end
    if (wb_en) begin
      case (cmd.uop.dst)
        DST_PX:  pt[0]  <= wb_val;
        DST_PY:  pt[1]  <= wb_val;
        DST_PZ:  pt[2]  <= wb_val;
        DST_T0:  tmp[0] <= wb_val;
        DST_T1:  tmp[1] <= wb_val;
        DST_T2:  tmp[2] <= wb_val;
        DST_KX:  kv[0]  <= wb_val;
        DST_KY:  kv[1]  <= wb_val;
        DST_KZ:  kv[2]  <= wb_val;
        default: ;
      endcase
      if (k_wr) begin
        case (cmd.uop.acc)
          ACC_LOAD: acc[k_lane] <= k_ext;
          ACC_ONE:  acc[k_lane] <= acc[k_lane] + k_ext;
          ACC_TWO:  acc[k_lane] <= acc[k_lane] + (k_ext <<< 1);
          default:  ;
        endcase
      end
    end
  end

  // The weighted sum plus three, offset to stay positive, is divided by six
  // four bits a cycle; the offset is taken back out of the quotient at commit.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (cmd.div_init) begin
        dvd[i] <= ACC_W'(acc[i] + 36'sd3 + DIV_OFFSET);
        rem[i] <= '0;
      end else if (cmd.div_step) begin
        dvd[i] <= {dvd[i][ACC_W-5:0], div6_digit(rem[i], dvd[i][ACC_W-1:ACC_W-4]).quo};
        rem[i] <= div6_digit(rem[i], dvd[i][ACC_W-1:ACC_W-4]).rem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_init) begin
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + 1'b1;
    end
  end

  assign sts.div_last = (div_cnt == DIV_CNT_W'(DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      coord[0] <= X_RESET;
      coord[1] <= '0;
      coord[2] <= '0;
    end else if (cmd.commit) begin
      for (int i = 0; i < 3; i++) begin
        coord[i] <= sat64(64'(coord[i]) + $signed({28'd0, dvd[i]}) - QUOT_OFFSET);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      pos_x <= coord[0];
      pos_y <= coord[1];
      pos_z <= coord[2];
    end
  end

  a_div_cnt: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (div_cnt < DIV_CNT_W'(DIV_STEPS)))
    else $error("division step counter overran");

  // The division always starts from a clear remainder.
  a_rem_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.div_init |=> (rem[0] == 3'd0 && rem[1] == 3'd0 && rem[2] == 3'd0))
    else $error("division remainder not cleared");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (rem[0] < 3'd6 && rem[1] < 3'd6 && rem[2] < 3'd6))
    else $error("division remainder out of range");

endmodule

`default_nettype wire

>>> verif/lorenz_rk4_stepper_test.sv
// Self-checking testbench for lorenz_rk4_stepper: drives tick items under random
// idling and back-pressure and compares every returned point against a local RK4
// predictor. Depends on lrk4_pkg for port widths and on the lorenz_rk4_stepper RTL.
`timescale 1ns / 1ps

module lorenz_rk4_stepper_test;

  localparam int CW = lrk4_pkg::COORD_W;
  localparam int SW = lrk4_pkg::SCALE_W;
  localparam int TW = lrk4_pkg::TICK_W;

  localparam longint SIGMA_FX = longint'(10) <<< 24;
  localparam longint BETA_FX  = 64'sd44739243;
  localparam longint HALF_FX  = longint'(1) <<< 23;
  localparam logic signed [CW-1:0] X_START = 32'sd1677722;
  localparam logic [SW-1:0] SCALE_START = 17'd65536;
  localparam logic [SW-1:0] SCALE_TOP   = 17'd131071;

  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 275;
  localparam int LONG_HOLD   = 800;
  localparam int TAIL_CYCLES = 120;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PRINT_CAP   = 25;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } point_t;

  // Keeps its own copy of the point and of rho_scale, predicts the next point
  // for every accepted tick and checks returned points in order.
  class point_tracker;
    logic signed [CW-1:0] px, py, pz;
    logic [SW-1:0] rho_scale;
    point_t due_points[$];
    int errors;
    int checked;

    function new();
      px = X_START;
      py = '0;
      pz = '0;
      rho_scale = SCALE_START;
      errors = 0;
      checked = 0;
    endfunction

    function int pending();
      return due_points.size();
    endfunction

    task report(string msg);
      errors++;
      // Past the cap the count still grows, but the log stays short.
      if (errors <= PRINT_CAP) $display("MISMATCH %0d: %s", errors, msg);
    endtask

    function logic signed [CW-1:0] clamp(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[CW-1:0];
    endfunction

    function logic signed [CW-1:0] fx_add(longint a, longint b);
      return clamp(a + b);
    endfunction

    function logic signed [CW-1:0] fx_sub(longint a, longint b);
      return clamp(a - b);
    endfunction

    // Product rounded half up at bit 24; the arithmetic shift floors.
    function logic signed [CW-1:0] fx_mul(longint a, longint b);
      longint p;
      p = a * b;
      return clamp((p + HALF_FX) >>> 24);
    endfunction

    function void slope(input logic signed [CW-1:0] x, y, z, rho, dt,
                        output logic signed [CW-1:0] kx, ky, kz);
      logic signed [CW-1:0] dx, dy, dz;
      dx = fx_mul(SIGMA_FX, fx_sub(y, x));
      dy = fx_sub(fx_mul(x, fx_sub(rho, z)), y);
      dz = fx_sub(fx_mul(x, y), fx_mul(BETA_FX, z));
      kx = fx_mul(dx, dt);
      ky = fx_mul(dy, dt);
      kz = fx_mul(dz, dt);
    endfunction

    // Weighted sum of the four slopes, divided by six rounding half up.
    function logic signed [CW-1:0] blend(logic signed [CW-1:0] s, k1, k2, k3, k4);
      longint v, q;
      v = longint'(k1) + 2 * longint'(k2) + 2 * longint'(k3) + longint'(k4) + 3;
      q = v / 6;
      if (v < 0 && (v % 6) != 0) q = q - 1;
      return clamp(longint'(s) + q);
    endfunction

    function void rk4_advance(logic [TW-1:0] ts);
      logic signed [CW-1:0] dt, rho;
      logic signed [CW-1:0] ax, ay, az, bx, by, bz, cx, cy, cz, ex, ey, ez;
      point_t nxt;
      dt  = int'(ts) * 10 * 256;
      rho = int'(rho_scale) * 28 * 256;
      slope(px, py, pz, rho, dt, ax, ay, az);
      slope(fx_add(px, fx_mul(ax, HALF_FX)), fx_add(py, fx_mul(ay, HALF_FX)),
            fx_add(pz, fx_mul(az, HALF_FX)), rho, dt, bx, by, bz);
      slope(fx_add(px, fx_mul(bx, HALF_FX)), fx_add(py, fx_mul(by, HALF_FX)),
            fx_add(pz, fx_mul(bz, HALF_FX)), rho, dt, cx, cy, cz);
      slope(fx_add(px, cx), fx_add(py, cy), fx_add(pz, cz), rho, dt, ex, ey, ez);
      nxt.x = blend(px, ax, bx, cx, ex);
      nxt.y = blend(py, ay, by, cy, ey);
      nxt.z = blend(pz, az, bz, cz, ez);
      px = nxt.x;
      py = nxt.y;
      pz = nxt.z;
      due_points.push_back(nxt);
    endfunction

    task check_point(logic signed [CW-1:0] x, y, z);
      point_t exp_pt;
      if (due_points.size() == 0) begin
        report($sformatf("point (%0d, %0d, %0d) arrived with none due", x, y, z));
      end else begin
        exp_pt = due_points.pop_front();
        if (x !== exp_pt.x)
          report($sformatf("point %0d pos_x %0d, wanted %0d", checked, x, exp_pt.x));
        if (y !== exp_pt.y)
          report($sformatf("point %0d pos_y %0d, wanted %0d", checked, y, exp_pt.y));
        if (z !== exp_pt.z)
          report($sformatf("point %0d pos_z %0d, wanted %0d", checked, z, exp_pt.z));
      end
      checked++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [SW-1:0] cfg_wr_data;
  logic in_valid;
  logic in_stall;
  logic [TW-1:0] time_step;
  logic out_valid;
  logic out_stall;
  logic signed [CW-1:0] pos_x, pos_y, pos_z;

  point_tracker board;
  bit src_gaps = 1'b0;
  bit sink_gaps = 1'b0;
  bit hold_request = 1'b0;
  int sent = 0;
  int unsigned cycles = 0;
  logic [TW-1:0] corner_ticks [0:19];

  lorenz_rk4_stepper DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .time_step  (time_step),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("lorenz_rk4_stepper regression: fail");
      $finish;
    end
  end

  // Result side: checks each accepted point and decides the stall for the
  // next edge, including the long hold-off that lets the block back up.
  initial begin : result_sink
    int burst;
    burst = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) board.check_point(pos_x, pos_y, pos_z);
      if (burst > 0) begin
        burst--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        burst = LONG_HOLD;
      end else if (sink_gaps && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 9);
      end
      out_stall <= (burst > 0);
    end
  end

  task automatic send_tick(input logic [TW-1:0] ts);
    if (src_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    time_step <= ts;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.rk4_advance(ts);
    sent++;
  endtask

  task automatic drain_points();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic write_scale(input logic [SW-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.rho_scale = v;
  endtask

  // Mostly ticks that keep the integration well behaved, with rare long ones
  // that push the point into saturation.
  function automatic logic [TW-1:0] pick_tick();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return TW'($urandom);
    if (r < 6) return '0;
    if (r < 20) return TW'($urandom_range(400, 2000));
    return TW'($urandom_range(1, 400));
  endfunction

  initial begin : stimulus
    logic [SW-1:0] scale;
    board = new();
    rst         <= 1'b1;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_valid    <= 1'b0;
    time_step   <= '0;
    // A zero tick leaves the point where it is but still returns it; the
    // long ticks near the end drive the coordinates into saturation.
    corner_ticks = '{16'd0, 16'd1, 16'd2, 16'd7, 16'd66, 16'd100, 16'd0, 16'd328,
                     16'd655, 16'd1000, 16'd2000, 16'd3277, 16'd6554, 16'h00FF,
                     16'h5555, 16'hAAAA, 16'h7FFF, 16'h8000, 16'hFFFF, 16'd0};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    foreach (corner_ticks[i]) send_tick(corner_ticks[i]);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_points();
      case (ph)
        0: scale = SCALE_TOP;
        1: scale = '0;
        2: scale = SW'($urandom_range(0, 65536));
        3: scale = SCALE_START;
        4: scale = SW'($urandom_range(1, 131071));
        default: scale = 17'd45875;
      endcase
      write_scale(scale);
      src_gaps  = (ph != PHASES - 1);
      sink_gaps = (ph != PHASES - 1);
      if (ph == 2) hold_request = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Keep offering items without a break while the output is held off.
        if (ph == 2) src_gaps = (n >= 24);
        if (ph == 3 && n == PHASE_ITEMS / 2) drain_points();
        send_tick(pick_tick());
      end
    end

    drain_points();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.pending() != 0)
      board.report($sformatf("%0d points still due at the end", board.pending()));

    $display("Sent %0d tick items over %0d rho_scale settings (0, 1.0 and 131071 among them);",
             sent, PHASES + 1);
    $display("%0d points checked under random idling, a %0d-cycle output hold and a drain.",
             board.checked, LONG_HOLD);
    if (board.errors == 0) begin
      $display("lorenz_rk4_stepper regression: pass");
    end else begin
      $display("lorenz_rk4_stepper regression: fail");
    end
    $finish;
  end

endmodule
